### rtl/particle_euler_integrator_defines.svh
// Assertion macros for the particle Euler integrator checker.
// Depends on nothing; included by the checker file.
`ifndef PARTICLE_EULER_INTEGRATOR_DEFINES_SVH
`define PARTICLE_EULER_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PEI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pei check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PEI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pei check failed");

`endif

### rtl/pei_pkg.sv
// Shared types, codes and saturating helpers of the particle Euler integrator.
// No dependencies; used by every RTL module through scoped names.
`default_nettype none
package pei_pkg;

  typedef enum logic [1:0] {
    REQ_ADD_FORCE = 2'd0,
    REQ_UPDATE    = 2'd1,
    REQ_SET_POS   = 2'd2,
    REQ_SET_VEL   = 2'd3
  } req_t;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN  = 8'd3;

  localparam logic [31:0] MASS_FLOOR = 32'd7;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FDIV,
    ST_FDIV_W,
    ST_SQ,
    ST_SQ_W,
    ST_MSQ,
    ST_MSQ_W,
    ST_ROOT,
    ST_SMUL,
    ST_SMUL_W,
    ST_SDIV,
    ST_SDIV_W,
    ST_PMUL,
    ST_PMUL_W
  } state_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] from_mag(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag >= 64'h0000_0000_8000_0000) return 32'h8000_0000;
      return ~mag[31:0] + 32'd1;
    end
    if (mag >= 64'h0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

endpackage
`default_nettype wire

### rtl/pei_mul.sv
// Bit-serial 32x32 unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pei_pkg for the request struct.
`default_nettype none
module pei_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pei_pkg::mul_req_t req,
  output logic                   done,
  output logic [63:0]            prod
);

  logic [31:0] a_r, a_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sum;

  always_comb begin
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : 33'd0);
    if (req.start) begin
      a_nxt    = req.a;
      lo_nxt   = req.b;
      hi_nxt   = '0;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // add and shift the product right by one
      hi_nxt = sum[32:1];
      lo_nxt = {sum[0], lo_r[31:1]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule
`default_nettype wire

### rtl/pei_div.sv
// Restoring 64/32 unsigned divider, one quotient bit per cycle.
// Depends on pei_pkg for the request struct.
`default_nettype none
module pei_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pei_pkg::div_req_t req,
  output logic                   done,
  output logic [63:0]            quo
);

  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[63]};
    diff     = trial - {1'b0, den_r};
    if (req.start) begin
      q_nxt    = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = 6'd63;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[31:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

### rtl/particle_euler_integrator.sv
// Explicit Euler integrator for one particle in Q16.16 fixed point.
// Depends on pei_pkg, pei_mul and pei_div.
//
// Usage: drive in_req_type and in_vec_x/y/z and raise start while busy is low;
// the item is taken at that clock edge. Add-force, set-position and
// set-velocity items take effect at that edge and give no result; busy stays
// low. An update item raises busy and, when done, pulses out_valid for one
// cycle with the new position and velocity on out_pos_* and out_vel_*; busy
// is low in that same cycle, so the next item may be started at once.
// The receiver cannot stall; the result shows for its single strobe cycle.
// An update runs on one shared bit-serial multiplier and one shared
// restoring divider: three force divisions plus three position products.
// With limiting on and the speed above max_speed, three squares, one square
// of max_speed, a square root and three multiply-divide rescales are added;
// with limiting on but not exceeded, the three squares and the square of
// max_speed are added.
// Configuration writes via cfg_we/cfg_index/cfg_wdata take effect at once.
// Reset (synchronous, rst_n low) zeroes the state and loads register defaults.
`default_nettype none
module particle_euler_integrator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_req_type,
  input  wire logic signed [31:0]              in_vec_x,
  input  wire logic signed [31:0]              in_vec_y,
  input  wire logic signed [31:0]              in_vec_z,
  output logic                                 out_valid,
  output logic signed [31:0]                   out_pos_x,
  output logic signed [31:0]                   out_pos_y,
  output logic signed [31:0]                   out_pos_z,
  output logic signed [31:0]                   out_vel_x,
  output logic signed [31:0]                   out_vel_y,
  output logic signed [31:0]                   out_vel_z,
  input  wire logic                            cfg_we,
  input  wire logic [pei_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_wdata
);

  pei_pkg::state_t state_r, state_nxt;

  logic [31:0] pos_r [3];
  logic [31:0] pos_nxt [3];
  logic [31:0] vel_r [3];
  logic [31:0] vel_nxt [3];
  logic [31:0] frc_r [3];
  logic [31:0] frc_nxt [3];

  logic [31:0] tstep_r, tstep_nxt;
  logic [31:0] mass_r, mass_nxt;
  logic [30:0] vmax_r, vmax_nxt;
  logic        lim_en_r, lim_en_nxt;

  logic [1:0]  ax_r, ax_nxt;
  logic [63:0] lsq_r, lsq_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  rcnt_r, rcnt_nxt;
  logic        oval_r, oval_nxt;

  pei_pkg::mul_req_t mul_req;
  pei_pkg::div_req_t div_req;
  logic        mul_done, div_done;
  logic [63:0] mul_prod, div_quo;

  logic [31:0] in_vec [3];
  logic [31:0] mass_eff;
  logic [31:0] vel_mag;
  logic [35:0] rcand;
  logic [35:0] rtrial;
  logic [35:0] rdiff;

  pei_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  pei_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_vec[0] = in_vec_x;
  assign in_vec[1] = in_vec_y;
  assign in_vec[2] = in_vec_z;
  assign mass_eff  = (mass_r < pei_pkg::MASS_FLOOR) ? pei_pkg::MASS_FLOOR : mass_r;
  assign vel_mag   = pei_pkg::mag32(vel_r[ax_r]);
  assign rcand     = {rem_r, rad_r[63:62]};
  assign rtrial    = {2'b00, root_r, 2'b01};
  assign rdiff     = rcand - rtrial;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    vel_nxt    = vel_r;
    frc_nxt    = frc_r;
    tstep_nxt  = tstep_r;
    mass_nxt   = mass_r;
    vmax_nxt   = vmax_r;
    lim_en_nxt = lim_en_r;
    ax_nxt     = ax_r;
    lsq_nxt    = lsq_r;
    rad_nxt    = rad_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    rcnt_nxt   = rcnt_r;
    oval_nxt   = 1'b0;
    mul_req    = '0;
    div_req    = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        pei_pkg::CFG_TIME_STEP: tstep_nxt  = cfg_wdata;
        pei_pkg::CFG_MASS:      mass_nxt   = cfg_wdata;
        pei_pkg::CFG_MAX_SPEED: vmax_nxt   = cfg_wdata[30:0];
        pei_pkg::CFG_LIMIT_EN:  lim_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    unique case (state_r)
      pei_pkg::ST_IDLE: begin
        if (start) begin
          unique case (pei_pkg::req_t'(in_req_type))
            pei_pkg::REQ_ADD_FORCE: begin
              for (int i = 0; i < 3; i++) frc_nxt[i] = pei_pkg::sat_add32(frc_r[i], in_vec[i]);
            end
            pei_pkg::REQ_SET_POS: pos_nxt = in_vec;
            pei_pkg::REQ_SET_VEL: vel_nxt = in_vec;
            pei_pkg::REQ_UPDATE: begin
              ax_nxt    = 2'd0;
              state_nxt = pei_pkg::ST_FDIV;
            end
            default: ;
          endcase
        end
      end
      pei_pkg::ST_FDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, pei_pkg::mag32(frc_r[ax_r]), 16'd0};
        div_req.den   = mass_eff;
        state_nxt     = pei_pkg::ST_FDIV_W;
      end
      pei_pkg::ST_FDIV_W: begin
        if (div_done) begin
          vel_nxt[ax_r] = pei_pkg::sat_add32(vel_r[ax_r],
                                             pei_pkg::from_mag(frc_r[ax_r][31], div_quo));
          frc_nxt[ax_r] = '0;
          if (ax_r == 2'd2) begin
            ax_nxt    = 2'd0;
            lsq_nxt   = '0;
            state_nxt = lim_en_r ? pei_pkg::ST_SQ : pei_pkg::ST_PMUL;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = pei_pkg::ST_FDIV;
          end
        end
      end
      pei_pkg::ST_SQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = vel_mag;
        mul_req.b     = vel_mag;
        state_nxt     = pei_pkg::ST_SQ_W;
      end
      pei_pkg::ST_SQ_W: begin
        if (mul_done) begin
          lsq_nxt = lsq_r + mul_prod;
          if (ax_r == 2'd2) begin
            ax_nxt    = 2'd0;
            state_nxt = pei_pkg::ST_MSQ;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = pei_pkg::ST_SQ;
          end
        end
      end
      pei_pkg::ST_MSQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = {1'b0, vmax_r};
        mul_req.b     = {1'b0, vmax_r};
        state_nxt     = pei_pkg::ST_MSQ_W;
      end
      pei_pkg::ST_MSQ_W: begin
        if (mul_done) begin
          if (lsq_r > mul_prod) begin
            rad_nxt   = lsq_r;
            rem_nxt   = '0;
            root_nxt  = '0;
            rcnt_nxt  = 5'd31;
            state_nxt = pei_pkg::ST_ROOT;
          end else begin
            state_nxt = pei_pkg::ST_PMUL;
          end
        end
      end
      pei_pkg::ST_ROOT: begin
        // take two radicand bits per cycle, one root bit out
        rad_nxt = {rad_r[61:0], 2'b00};
        if (rcand >= rtrial) begin
          rem_nxt  = rdiff[33:0];
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = rcand[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        rcnt_nxt = rcnt_r - 5'd1;
        if (rcnt_r == 5'd0) begin
          ax_nxt    = 2'd0;
          state_nxt = pei_pkg::ST_SMUL;
        end
      end
      pei_pkg::ST_SMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = vel_mag;
        mul_req.b     = {1'b0, vmax_r};
        state_nxt     = pei_pkg::ST_SMUL_W;
      end
      pei_pkg::ST_SMUL_W: begin
        if (mul_done) state_nxt = pei_pkg::ST_SDIV;
      end
      pei_pkg::ST_SDIV: begin
        div_req.start = 1'b1;
        div_req.num   = mul_prod;
        div_req.den   = root_r;
        state_nxt     = pei_pkg::ST_SDIV_W;
      end
      pei_pkg::ST_SDIV_W: begin
        if (div_done) begin
          vel_nxt[ax_r] = pei_pkg::from_mag(vel_r[ax_r][31], div_quo);
          if (ax_r == 2'd2) begin
            ax_nxt    = 2'd0;
            state_nxt = pei_pkg::ST_PMUL;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = pei_pkg::ST_SMUL;
          end
        end
      end
      pei_pkg::ST_PMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = vel_mag;
        mul_req.b     = tstep_r;
        state_nxt     = pei_pkg::ST_PMUL_W;
      end
      pei_pkg::ST_PMUL_W: begin
        if (mul_done) begin
          pos_nxt[ax_r] = pei_pkg::sat_add32(pos_r[ax_r],
                            pei_pkg::from_mag(vel_r[ax_r][31], {16'd0, mul_prod[63:16]}));
          if (ax_r == 2'd2) begin
            oval_nxt  = 1'b1;
            state_nxt = pei_pkg::ST_IDLE;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = pei_pkg::ST_PMUL;
          end
        end
      end
      default: state_nxt = pei_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pei_pkg::ST_IDLE;
      tstep_r  <= 32'h0001_0000;
      mass_r   <= 32'h0001_0000;
      vmax_r   <= 31'h7FFF_FFFF;
      lim_en_r <= 1'b0;
      oval_r   <= 1'b0;
      ax_r     <= '0;
      rcnt_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        frc_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      tstep_r  <= tstep_nxt;
      mass_r   <= mass_nxt;
      vmax_r   <= vmax_nxt;
      lim_en_r <= lim_en_nxt;
      oval_r   <= oval_nxt;
      ax_r     <= ax_nxt;
      rcnt_r   <= rcnt_nxt;
      pos_r    <= pos_nxt;
      vel_r    <= vel_nxt;
      frc_r    <= frc_nxt;
    end
    lsq_r  <= lsq_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy      = (state_r != pei_pkg::ST_IDLE);
  assign out_valid = oval_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_vel_x = vel_r[0];
  assign out_vel_y = vel_r[1];
  assign out_vel_z = vel_r[2];

endmodule
`default_nettype wire

### rtl/pei_checker.sv
// Port-level checks on the particle Euler integrator, bound to the top level.
// Depends on particle_euler_integrator_defines.svh and pei_pkg.
`default_nettype none
`include "particle_euler_integrator_defines.svh"
module pei_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_req_type,
  input wire logic       out_valid
);

  logic take_upd;
  logic take_other;

  assign take_upd   = start && !busy && (in_req_type == pei_pkg::REQ_UPDATE);
  assign take_other = start && !busy && (in_req_type != pei_pkg::REQ_UPDATE);

  `PEI_ASSERT_NOW(a_result_after_busy, clk, rst_n, out_valid, $past(busy))
  `PEI_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `PEI_ASSERT_NEXT(a_update_goes_busy, clk, rst_n, take_upd, busy && !out_valid)
  `PEI_ASSERT_NEXT(a_other_stays_idle, clk, rst_n, take_other, !busy && !out_valid)

endmodule

bind particle_euler_integrator pei_checker u_pei_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req_type(in_req_type),
  .out_valid  (out_valid)
);
`default_nettype wire
